// ===== rtl/depth_to_space_address_map_unit_assert.svh =====
// Assertion macros shared by the depth-to-space address map RTL.
`ifndef DEPTH_TO_SPACE_ADDRESS_MAP_UNIT_ASSERT_SVH
`define DEPTH_TO_SPACE_ADDRESS_MAP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2S_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D2S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/d2s_pkg.sv =====
// Shared types and constants of the depth-to-space address map unit.
package d2s_pkg;

   // Default geometry of the block.
   localparam int NUM_DIMS_DEF   = 4;
   localparam int INDEX_BITS_DEF = 24;

   // Field and register widths.
   localparam int IDX_FIELD_W = 24;
   localparam int VALUE_W     = 16;
   localparam int DIM_W       = 16;
   localparam int BS_W        = 5;
   localparam int LAYOUT_W    = 2;
   localparam int MAX_DIMS    = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Layout codes.
   localparam logic [LAYOUT_W-1:0] LAYOUT_PLANAR      = 2'd0;
   localparam logic [LAYOUT_W-1:0] LAYOUT_INTERLEAVED = 2'd1;

   // Register indexes, in the order of their byte addresses.
   typedef enum logic [2:0] {
      REG_LAYOUT      = 3'd0,
      REG_DEPTH_FIRST = 3'd1,
      REG_BLOCK_SIZE  = 3'd2,
      REG_DIM_INNER   = 3'd3,
      REG_DIM_SECOND  = 3'd4,
      REG_DIM_THIRD   = 3'd5,
      REG_DIM_OUTER   = 3'd6
   } csr_reg_type;

   // One request: an element index and its raw value.
   typedef struct packed {
      logic [IDX_FIELD_W-1:0] in_index;
      logic [VALUE_W-1:0]     element_value;
   } req_type;

   // One result: the remapped index and the unchanged value.
   typedef struct packed {
      logic [IDX_FIELD_W-1:0] out_index;
      logic [VALUE_W-1:0]     out_value;
   } rsp_type;

endpackage

// ===== rtl/d2s_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module d2s_divider #(
   parameter int DIVIDEND_W = d2s_pkg::INDEX_BITS_DEF,
   parameter int SIDE_W     = d2s_pkg::VALUE_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [DIVIDEND_W-1:0]     in_dividend,
   input  logic [d2s_pkg::DIM_W-1:0] in_divisor,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [DIVIDEND_W-1:0]     out_quotient,
   output logic [d2s_pkg::DIM_W-1:0] out_remainder,
   output logic [SIDE_W-1:0]         out_side
);

   localparam int RW = d2s_pkg::DIM_W;

   logic                  valid_ff [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] x_ff     [DIVIDEND_W];
   logic [RW-1:0]         r_ff     [DIVIDEND_W];
   logic [SIDE_W-1:0]     side_ff  [DIVIDEND_W];

   // Each stage shifts in one dividend bit and decides one quotient bit. Users
   // must hold the configured divisor while requests are in flight; not enforced.
   for (genvar s = 0; s < DIVIDEND_W; s++) begin : g_stage
      logic                  v_src;
      logic [DIVIDEND_W-1:0] x_src;
      logic [RW-1:0]         r_src;
      logic [SIDE_W-1:0]     side_src;
      logic [RW:0]           trial;
      logic                  ge;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign x_src    = in_dividend;
         assign r_src    = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign x_src    = x_ff[s-1];
         assign r_src    = r_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      assign trial = {r_src, x_src[DIVIDEND_W-1]};
      assign ge    = trial >= {1'b0, in_divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[s]    <= {x_src[DIVIDEND_W-2:0], ge};
         r_ff[s]    <= ge ? RW'(trial - {1'b0, in_divisor}) : trial[RW-1:0];
         side_ff[s] <= side_src;
      end
   end

   assign out_valid     = valid_ff[DIVIDEND_W-1];
   assign out_quotient  = x_ff[DIVIDEND_W-1];
   assign out_remainder = r_ff[DIVIDEND_W-1];
   assign out_side      = side_ff[DIVIDEND_W-1];

endmodule

// ===== rtl/depth_to_space_address_map_unit.sv =====
// Path to the strobe: request register, dividers, weighting stage, pairwise sums, result register.
// Throughput: one request per cycle while not busy; the chain of bit-per-stage dividers sets the depth.
// Results are strobed for one cycle; the receiver cannot stall.
// After reset and after every register write, busy is high while the channel quotient and
// the output weights are recomputed.
// Reset is synchronous and active high; only configuration, sequencer and valid registers are reset.
`include "depth_to_space_address_map_unit_assert.svh"

module depth_to_space_address_map_unit #(
   parameter int NUM_DIMS   = d2s_pkg::NUM_DIMS_DEF,
   parameter int INDEX_BITS = d2s_pkg::INDEX_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  d2s_pkg::req_type               req_item,
   output logic                           rsp_strobe,
   output d2s_pkg::rsp_type               rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [d2s_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [d2s_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [d2s_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int K      = NUM_DIMS - 2;
   localparam int N_RD   = 2 * K + 2;
   localparam int ORD_W  = $clog2(N_RD);
   localparam int HALF   = N_RD / 2;
   localparam int DIM_W  = d2s_pkg::DIM_W;
   localparam int VAL_W  = d2s_pkg::VALUE_W;
   localparam int BS_W   = d2s_pkg::BS_W;
   localparam int BB_W   = 2 * BS_W;
   localparam int CNT_W  = $clog2(DIM_W + 1);
   localparam int DATA_W = d2s_pkg::CSR_DATA_W;
   localparam int SIDE_W = N_RD * VAL_W;

   localparam logic [CNT_W-1:0] CHDIV_LAST = CNT_W'(DIM_W);
   localparam logic [ORD_W-1:0] WCNT_LAST  = ORD_W'(N_RD - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CHDIV  = 3'b010,
      S_WEIGHT = 3'b100
   } seq_state_type;

   // Configuration registers.
   logic [d2s_pkg::LAYOUT_W-1:0] layout_ff;
   logic                         depth_first_ff;
   logic [BS_W-1:0]              block_size_ff;
   logic [DIM_W-1:0]             dim_ff [d2s_pkg::MAX_DIMS];

   logic       cfg_write;
   logic [2:0] csr_index;

   assign cfg_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff      <= d2s_pkg::LAYOUT_PLANAR;
         depth_first_ff <= 1'b0;
         block_size_ff  <= BS_W'(2);
         for (int i = 0; i < d2s_pkg::MAX_DIMS; i++) begin
            dim_ff[i] <= DIM_W'(1);
         end
      end else if (cfg_write) begin
         case (csr_index)
            d2s_pkg::REG_LAYOUT:      layout_ff      <= pwdata[d2s_pkg::LAYOUT_W-1:0];
            d2s_pkg::REG_DEPTH_FIRST: depth_first_ff <= pwdata[0];
            d2s_pkg::REG_BLOCK_SIZE:  block_size_ff  <= pwdata[BS_W-1:0];
            d2s_pkg::REG_DIM_INNER:   dim_ff[0]      <= pwdata[DIM_W-1:0];
            d2s_pkg::REG_DIM_SECOND:  dim_ff[1]      <= pwdata[DIM_W-1:0];
            d2s_pkg::REG_DIM_THIRD:   dim_ff[2]      <= pwdata[DIM_W-1:0];
            d2s_pkg::REG_DIM_OUTER:   dim_ff[3]      <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (csr_index)
         d2s_pkg::REG_LAYOUT:      prdata = DATA_W'(layout_ff);
         d2s_pkg::REG_DEPTH_FIRST: prdata = DATA_W'(depth_first_ff);
         d2s_pkg::REG_BLOCK_SIZE:  prdata = DATA_W'(block_size_ff);
         d2s_pkg::REG_DIM_INNER:   prdata = DATA_W'(dim_ff[0]);
         d2s_pkg::REG_DIM_SECOND:  prdata = DATA_W'(dim_ff[1]);
         d2s_pkg::REG_DIM_THIRD:   prdata = DATA_W'(dim_ff[2]);
         d2s_pkg::REG_DIM_OUTER:   prdata = DATA_W'(dim_ff[3]);
         default:                  prdata = '0;
      endcase
   end

   // Set-up sequencer: channel quotient, then one output weight per cycle; a register write restarts it.
   seq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ORD_W-1:0]     wcnt_ff, wcnt_in;
   logic [DIM_W-1:0]     qx_ff;
   logic [BB_W-1:0]      rem_ff;
   logic [INDEX_BITS-1:0] acc_ff;
   logic [INDEX_BITS-1:0] w_ff [N_RD];

   logic [BB_W-1:0]  bb;
   logic [DIM_W-1:0] chan_dim;
   logic [DIM_W-1:0] chq;
   logic [BB_W:0]    ch_trial;
   logic             ch_ge;

   assign bb       = BB_W'(block_size_ff) * BB_W'(block_size_ff);
   assign chan_dim = (layout_ff == d2s_pkg::LAYOUT_PLANAR) ? dim_ff[K] : dim_ff[0];
   assign chq      = (bb == '0) ? '0 : qx_ff;
   assign ch_trial = {rem_ff, qx_ff[DIM_W-1]};
   assign ch_ge    = ch_trial >= {1'b0, bb};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wcnt_in  = wcnt_ff;
      if (cfg_write) begin
         state_in = S_CHDIV;
         cnt_in   = '0;
      end else begin
         case (state_ff)
            S_CHDIV: begin
               if (cnt_ff == CHDIV_LAST) begin
                  state_in = S_WEIGHT;
                  wcnt_in  = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            S_WEIGHT: begin
               if (wcnt_ff == WCNT_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  wcnt_in = wcnt_ff + 1'b1;
               end
            end
            S_IDLE: ;
            default: begin
               state_in = S_CHDIV;
               cnt_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CHDIV;
         cnt_ff   <= '0;
         wcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wcnt_ff  <= wcnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Radix and order tables of the reshaped dimensions.
   logic [DIM_W-1:0] rd_c [N_RD];
   logic [ORD_W-1:0] ord_c [N_RD];
   logic [DIM_W-1:0] rd_ff [N_RD];
   logic             cfg_ok_c;
   logic             cfg_ok_ff;

   always_comb begin
      logic [DIM_W-1:0] bs;
      bs = DIM_W'(block_size_ff);
      for (int i = 0; i < N_RD; i++) begin
         rd_c[i]  = '0;
         ord_c[i] = '0;
      end
      if (layout_ff == d2s_pkg::LAYOUT_PLANAR) begin
         rd_c[N_RD-1] = dim_ff[K+1];
         if (!depth_first_ff) begin
            for (int i = 0; i < K; i++) begin
               rd_c[i]         = dim_ff[i];
               rd_c[i+K+1]     = bs;
               ord_c[2*i]      = ORD_W'(K + 1 + i);
               ord_c[2*i+1]    = ORD_W'(i);
            end
            rd_c[K]    = chq;
            ord_c[2*K] = ORD_W'(K);
         end else begin
            for (int i = 0; i < K; i++) begin
               rd_c[i]         = dim_ff[i];
               rd_c[i+K]       = bs;
               ord_c[2*i]      = ORD_W'(K + i);
               ord_c[2*i+1]    = ORD_W'(i);
            end
            rd_c[2*K]  = chq;
            ord_c[2*K] = ORD_W'(2 * K);
         end
         ord_c[N_RD-1] = ORD_W'(N_RD - 1);
      end else if (layout_ff == d2s_pkg::LAYOUT_INTERLEAVED) begin
         rd_c[N_RD-1] = dim_ff[K+1];
         if (!depth_first_ff) begin
            for (int i = 0; i < K; i++) begin
               rd_c[i+K+1]     = dim_ff[i+1];
               rd_c[i+1]       = bs;
               ord_c[2*i+1]    = ORD_W'(i + 1);
               ord_c[2*i+2]    = ORD_W'(K + i + 1);
            end
            rd_c[0]  = chq;
            ord_c[0] = '0;
         end else begin
            for (int i = 0; i < K; i++) begin
               rd_c[i+K+1]     = dim_ff[i+1];
               rd_c[i]         = bs;
               ord_c[2*i]      = ORD_W'(K + i);
               ord_c[2*i+1]    = ORD_W'(i);
            end
            rd_c[K]    = chq;
            ord_c[2*K] = ORD_W'(2 * K);
         end
         ord_c[N_RD-1] = ORD_W'(N_RD - 1);
      end
   end

   // A layout without a mapping or any zero radix gives no result.
   always_comb begin
      cfg_ok_c = (layout_ff == d2s_pkg::LAYOUT_PLANAR) ||
                 (layout_ff == d2s_pkg::LAYOUT_INTERLEAVED);
      for (int i = 0; i < N_RD; i++) begin
         if (rd_c[i] == '0) begin
            cfg_ok_c = 1'b0;
         end
      end
   end

   // Sequencer datapath: bit-serial channel divide, then running weight products.
   always_ff @(posedge clock) begin
      if (state_ff == S_CHDIV && !cfg_write) begin
         if (cnt_ff == '0) begin
            qx_ff  <= chan_dim;
            rem_ff <= '0;
         end else begin
            qx_ff  <= {qx_ff[DIM_W-2:0], ch_ge};
            rem_ff <= ch_ge ? BB_W'(ch_trial - {1'b0, bb}) : ch_trial[BB_W-1:0];
         end
         if (cnt_ff == CHDIV_LAST) begin
            acc_ff <= INDEX_BITS'(1);
         end
      end
      if (state_ff == S_WEIGHT && !cfg_write) begin
         w_ff[ord_c[wcnt_ff]] <= acc_ff;
         acc_ff <= INDEX_BITS'(acc_ff * INDEX_BITS'(rd_c[ord_c[wcnt_ff]]));
      end
      for (int i = 0; i < N_RD; i++) begin
         rd_ff[i] <= rd_c[i];
      end
      cfg_ok_ff <= cfg_ok_c;
   end

   // Request register.
   logic                  v0_ff;
   logic [INDEX_BITS-1:0] x0_ff;
   logic [VAL_W-1:0]      val0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff   <= INDEX_BITS'(req_item.in_index);
      val0_ff <= req_item.element_value;
   end

   // Divider chain: each divider peels off one mixed-radix coordinate.
   // Side slot 0 carries the value, slot j+1 the coordinate j.
   logic                                v_s    [N_RD];
   logic [INDEX_BITS-1:0]               q_s    [N_RD];
   logic [N_RD-1:0][VAL_W-1:0]          side_s [N_RD];
   logic                                v_o    [N_RD-1];
   logic [INDEX_BITS-1:0]               quot_o [N_RD-1];
   logic [DIM_W-1:0]                    rem_o  [N_RD-1];
   logic [SIDE_W-1:0]                   side_o [N_RD-1];

   assign v_s[0] = v0_ff;
   assign q_s[0] = x0_ff;

   always_comb begin
      side_s[0]    = '0;
      side_s[0][0] = val0_ff;
   end

   for (genvar i = 0; i < N_RD - 1; i++) begin : g_div
      d2s_divider #(
         .DIVIDEND_W (INDEX_BITS),
         .SIDE_W     (SIDE_W)
      ) u_div (
         .clock         (clock),
         .reset         (reset),
         .in_valid      (v_s[i]),
         .in_dividend   (q_s[i]),
         .in_divisor    (rd_ff[i]),
         .in_side       (side_s[i]),
         .out_valid     (v_o[i]),
         .out_quotient  (quot_o[i]),
         .out_remainder (rem_o[i]),
         .out_side      (side_o[i])
      );

      assign v_s[i+1] = v_o[i];
      assign q_s[i+1] = quot_o[i];

      always_comb begin
         side_s[i+1]      = side_o[i];
         side_s[i+1][i+1] = rem_o[i];
      end
   end

   // Weighting stage: every coordinate times its output weight.
   logic [INDEX_BITS-1:0] coord_c [N_RD];
   logic                  vp_ff;
   logic [INDEX_BITS-1:0] prod_ff [N_RD];
   logic [VAL_W-1:0]      valp_ff;

   always_comb begin
      for (int j = 0; j < N_RD - 1; j++) begin
         coord_c[j] = INDEX_BITS'(side_s[N_RD-1][j+1]);
      end
      coord_c[N_RD-1] = q_s[N_RD-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= v_s[N_RD-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < N_RD; j++) begin
         prod_ff[j] <= INDEX_BITS'(coord_c[j] * w_ff[j]);
      end
      valp_ff <= side_s[N_RD-1][0];
   end

   // Pairwise sums.
   logic                  vs_ff;
   logic [INDEX_BITS-1:0] sum_ff [HALF];
   logic [VAL_W-1:0]      vals_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else begin
         vs_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int h = 0; h < HALF; h++) begin
         sum_ff[h] <= prod_ff[2*h] + prod_ff[2*h+1];
      end
      vals_ff <= valp_ff;
   end

   // Final sum and result register.
   logic [INDEX_BITS-1:0]           total_c;
   logic                            rsp_strobe_ff;
   logic [d2s_pkg::IDX_FIELD_W-1:0] rsp_index_ff;
   logic [VAL_W-1:0]                rsp_value_ff;

   always_comb begin
      total_c = '0;
      for (int h = 0; h < HALF; h++) begin
         total_c = total_c + sum_ff[h];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vs_ff && cfg_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= d2s_pkg::IDX_FIELD_W'(total_c);
      rsp_value_ff <= vals_ff;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_item.out_index = rsp_index_ff;
   assign rsp_item.out_value = rsp_value_ff;

   // Checks on the set-up sequencer.
   `D2S_ASSERT_NEXT(a_write_restarts, clock, reset, cfg_write, busy, "write did not raise busy")
   `D2S_ASSERT_SAME(a_chdiv_bound, clock, reset, state_ff == S_CHDIV, cnt_ff <= CHDIV_LAST, "divide count overran")
   `D2S_ASSERT_SAME(a_weight_bound, clock, reset, state_ff == S_WEIGHT, wcnt_ff <= WCNT_LAST, "weight count overran")

endmodule
